/* hdl/dipole_quadrupole_correction_assert.svh */
// Assertion helpers for the dipole/quadrupole correction block.
// They expect clk and rst_n in scope.
`ifndef DIPOLE_QUADRUPOLE_CORRECTION_ASSERT_SVH
`define DIPOLE_QUADRUPOLE_CORRECTION_ASSERT_SVH

// same-cycle implication
`define DQC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dqc_pkg.sv */
`default_nettype none

package dqc_pkg;

  localparam int FRAC      = 16;   // fractional bits of every value
  localparam int DIG_W     = 16;   // multiplier digit width
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 1;
  localparam int K_W       = 20;

  // -4pi/3 and 2pi/3 in Q.16, rounded to nearest
  localparam logic signed [K_W-1:0] K_GRAD  = -20'sd274517;
  localparam logic signed [K_W-1:0] K_TRACE = 20'sd137258;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_PARTICLE = 2'd1,
    OP_TARGET   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIPOLE_EN   = 2'd0,
    CFG_GRADIENT_EN = 2'd1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_Q, SRC_X, SRC_Y, SRC_Z, SRC_MX, SRC_MY, SRC_MZ,
    SRC_KG, SRC_KT, SRC_DX, SRC_DY, SRC_DZ, SRC_T, SRC_W,
    SRC_GX, SRC_GY, SRC_GZ, SRC_QT, SRC_P
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_DX, DST_DY, DST_DZ, DST_T, DST_W,
    DST_GX, DST_GY, DST_GZ, DST_QT
  } dst_t;

  // one sequencer step: optional multiply ma*mb into P, then dst = sat(aa + ab)
  typedef struct packed {
    logic mul;
    src_t ma;
    src_t mb;
    src_t aa;
    src_t ab;
    dst_t dst;
    logic last;
    logic gate;   // ends the sequence when dipole mode is off
  } uop_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic ovf;
  } mul_stat_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

  localparam logic [STEP_W-1:0] STEP_PART = 5'd0;
  localparam logic [STEP_W-1:0] STEP_TGT  = 5'd16;

  function automatic uop_t mk(logic mul, src_t ma, src_t mb, src_t aa, src_t ab,
                              dst_t dst, logic last, logic gate);
    uop_t u;
    u.mul  = mul;
    u.ma   = ma;
    u.mb   = mb;
    u.aa   = aa;
    u.ab   = ab;
    u.dst  = dst;
    u.last = last;
    u.gate = gate;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      // particle: dipole += q*p
      5'd0:  u = mk(1'b1, SRC_Q,  SRC_X,  SRC_DX,   SRC_P,  DST_DX, 1'b0, 1'b0);
      5'd1:  u = mk(1'b1, SRC_Q,  SRC_Y,  SRC_DY,   SRC_P,  DST_DY, 1'b0, 1'b0);
      5'd2:  u = mk(1'b1, SRC_Q,  SRC_Z,  SRC_DZ,   SRC_P,  DST_DZ, 1'b0, 1'b0);
      // r2, then trace += q*r2
      5'd3:  u = mk(1'b1, SRC_X,  SRC_X,  SRC_ZERO, SRC_P,  DST_W,  1'b0, 1'b0);
      5'd4:  u = mk(1'b1, SRC_Y,  SRC_Y,  SRC_W,    SRC_P,  DST_W,  1'b0, 1'b0);
      5'd5:  u = mk(1'b1, SRC_Z,  SRC_Z,  SRC_W,    SRC_P,  DST_W,  1'b0, 1'b0);
      5'd6:  u = mk(1'b1, SRC_Q,  SRC_W,  SRC_T,    SRC_P,  DST_T,  1'b0, 1'b1);
      // dipole mode: moments into dipole, 2*(m.p) into trace
      5'd7:  u = mk(1'b0, SRC_ZERO, SRC_ZERO, SRC_DX, SRC_MX, DST_DX, 1'b0, 1'b0);
      5'd8:  u = mk(1'b0, SRC_ZERO, SRC_ZERO, SRC_DY, SRC_MY, DST_DY, 1'b0, 1'b0);
      5'd9:  u = mk(1'b0, SRC_ZERO, SRC_ZERO, SRC_DZ, SRC_MZ, DST_DZ, 1'b0, 1'b0);
      5'd10: u = mk(1'b1, SRC_MX, SRC_X,  SRC_ZERO, SRC_P,  DST_W,  1'b0, 1'b0);
      5'd11: u = mk(1'b1, SRC_MY, SRC_Y,  SRC_W,    SRC_P,  DST_W,  1'b0, 1'b0);
      5'd12: u = mk(1'b1, SRC_MZ, SRC_Z,  SRC_W,    SRC_P,  DST_W,  1'b0, 1'b0);
      5'd13: u = mk(1'b0, SRC_ZERO, SRC_ZERO, SRC_W, SRC_W, DST_W,  1'b0, 1'b0);
      5'd14: u = mk(1'b0, SRC_ZERO, SRC_ZERO, SRC_T, SRC_W, DST_T,  1'b1, 1'b0);
      // target: gradient, scaled trace, then potential
      5'd16: u = mk(1'b1, SRC_KG, SRC_DX, SRC_ZERO, SRC_P,  DST_GX, 1'b0, 1'b0);
      5'd17: u = mk(1'b1, SRC_KG, SRC_DY, SRC_ZERO, SRC_P,  DST_GY, 1'b0, 1'b0);
      5'd18: u = mk(1'b1, SRC_KG, SRC_DZ, SRC_ZERO, SRC_P,  DST_GZ, 1'b0, 1'b0);
      5'd19: u = mk(1'b1, SRC_KT, SRC_T,  SRC_ZERO, SRC_P,  DST_QT, 1'b0, 1'b0);
      5'd20: u = mk(1'b1, SRC_GX, SRC_X,  SRC_ZERO, SRC_P,  DST_W,  1'b0, 1'b0);
      5'd21: u = mk(1'b1, SRC_GY, SRC_Y,  SRC_W,    SRC_P,  DST_W,  1'b0, 1'b0);
      5'd22: u = mk(1'b1, SRC_GZ, SRC_Z,  SRC_W,    SRC_P,  DST_W,  1'b0, 1'b0);
      5'd23: u = mk(1'b0, SRC_ZERO, SRC_ZERO, SRC_W, SRC_QT, DST_W, 1'b1, 1'b0);
      default: u = mk(1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b1, 1'b0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* hdl/dqc_chan_if.sv */
`default_nettype none

interface dqc_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] charge;
  logic signed [COORD_WIDTH-1:0] moment_x;
  logic signed [COORD_WIDTH-1:0] moment_y;
  logic signed [COORD_WIDTH-1:0] moment_z;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, charge,
                  moment_x, moment_y, moment_z, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pos_z, charge,
                moment_x, moment_y, moment_z, output ready);
endinterface

interface dqc_out_if #(parameter int ACC_WIDTH = 64);
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] potential_delta;
  logic signed [ACC_WIDTH-1:0] gradient_x;
  logic signed [ACC_WIDTH-1:0] gradient_y;
  logic signed [ACC_WIDTH-1:0] gradient_z;
  logic                        saturated;

  modport source (output valid, potential_delta, gradient_x, gradient_y, gradient_z,
                  saturated, input ready);
  modport sink (input valid, potential_delta, gradient_x, gradient_y, gradient_z,
                saturated, output ready);
endinterface

`default_nettype wire

/* hdl/dqc_mul.sv */
`default_nettype none

// Sign-magnitude multiplier, one 16-bit digit of b per cycle, MSB first.
// Result is floored to Q.16 and clamped to ACC_WIDTH.
module dqc_mul #(
  parameter int OPW       = 64,
  parameter int ACC_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dqc_pkg::mul_ctl_t           ctl,
  input  wire logic signed [OPW-1:0]       op_a,
  input  wire logic signed [OPW-1:0]       op_b,
  output dqc_pkg::mul_stat_t               stat,
  output logic signed [ACC_WIDTH-1:0]      result
);

  localparam int NDIG  = (OPW + dqc_pkg::DIG_W - 1) / dqc_pkg::DIG_W;
  localparam int UBW   = NDIG * dqc_pkg::DIG_W;
  localparam int PW    = OPW + UBW;
  localparam int SW    = PW + 1;
  localparam int CNT_W = $clog2(NDIG + 1);
  localparam int DW    = dqc_pkg::DIG_W;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t                     state_r;
  logic [OPW-1:0]              ua_r;
  logic [UBW-1:0]              ub_r;
  logic                        neg_r;
  logic [PW-1:0]               acc_r;
  logic [CNT_W-1:0]            cnt_r;
  logic signed [ACC_WIDTH-1:0] result_r;
  logic                        ovf_r;
  logic                        done_r;

  logic [OPW-1:0]              mag_a, mag_b;
  logic [DW-1:0]               digit;
  logic [OPW+DW-1:0]           pp;
  logic [PW-1:0]               acc_nxt;
  logic signed [SW-1:0]        prod_s, prod_q;
  logic [SW-ACC_WIDTH:0]       prod_hi;
  logic                        fits;
  logic signed [ACC_WIDTH-1:0] clamp_val;

  assign mag_a = op_a[OPW-1] ? (~unsigned'(op_a) + OPW'(1)) : unsigned'(op_a);
  assign mag_b = op_b[OPW-1] ? (~unsigned'(op_b) + OPW'(1)) : unsigned'(op_b);

  assign digit   = ub_r[UBW-1 -: DW];
  assign pp      = ua_r * digit;
  assign acc_nxt = {acc_r[PW-DW-1:0], {DW{1'b0}}} + PW'(pp);

  // apply sign, floor to 16 fractional bits, check range
  assign prod_s    = neg_r ? -signed'({1'b0, acc_r}) : signed'({1'b0, acc_r});
  assign prod_q    = prod_s >>> dqc_pkg::FRAC;
  assign prod_hi   = prod_q[SW-1:ACC_WIDTH-1];
  assign fits      = (&prod_hi) | ~(|prod_hi);
  assign clamp_val = fits ? prod_q[ACC_WIDTH-1:0] : (prod_q[SW-1] ? ACC_MIN : ACC_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (ctl.start) begin
            ua_r    <= mag_a;
            ub_r    <= UBW'(mag_b);
            neg_r   <= op_a[OPW-1] ^ op_b[OPW-1];
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= acc_nxt;
          ub_r  <= {ub_r[UBW-DW-1:0], {DW{1'b0}}};
          cnt_r <= CNT_W'(cnt_r + 1'b1);
          if (cnt_r == CNT_W'(NDIG - 1)) begin
            state_r <= M_FIN;
          end
        end
        M_FIN: begin
          result_r <= clamp_val;
          ovf_r    <= ~fits;
          done_r   <= 1'b1;
          state_r  <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign stat.idle = (state_r == M_IDLE);
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign result    = result_r;

endmodule

`default_nettype wire

/* hdl/dqc_core.sv */
`default_nettype none

// Step sequencer: holds the sums and scratch values, drives the shared
// multiplier and does the saturating add of each step.
module dqc_core #(
  parameter int COORD_WIDTH = 32,
  parameter int ACC_WIDTH   = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [1:0]                    op,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z,
  input  wire logic signed [COORD_WIDTH-1:0] charge,
  input  wire logic signed [COORD_WIDTH-1:0] moment_x,
  input  wire logic signed [COORD_WIDTH-1:0] moment_y,
  input  wire logic signed [COORD_WIDTH-1:0] moment_z,
  input  wire logic                          dip_en,
  output dqc_pkg::core_stat_t                stat,
  input  wire logic                          res_ready,
  output logic signed [ACC_WIDTH-1:0]        pot,
  output logic signed [ACC_WIDTH-1:0]        gx,
  output logic signed [ACC_WIDTH-1:0]        gy,
  output logic signed [ACC_WIDTH-1:0]        gz,
  output logic                               sat,
  output dqc_pkg::mul_ctl_t                  mul_ctl,
  output logic signed [((ACC_WIDTH > COORD_WIDTH) ? ACC_WIDTH : COORD_WIDTH)-1:0] mul_a,
  output logic signed [((ACC_WIDTH > COORD_WIDTH) ? ACC_WIDTH : COORD_WIDTH)-1:0] mul_b,
  input  wire dqc_pkg::mul_stat_t            mul_stat,
  input  wire logic signed [ACC_WIDTH-1:0]   mul_res
);

  localparam int OPW = (ACC_WIDTH > COORD_WIDTH) ? ACC_WIDTH : COORD_WIDTH;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {C_IDLE, C_ISSUE, C_WAIT, C_ADD, C_OUT} cstate_t;

  cstate_t                        state_r;
  logic [dqc_pkg::STEP_W-1:0]     step_r;
  logic                           tgt_r;
  logic                           ovf_r;
  logic signed [COORD_WIDTH-1:0]  x_r, y_r, z_r, q_r, mx_r, my_r, mz_r;
  logic signed [ACC_WIDTH-1:0]    dx_r, dy_r, dz_r, t_r;
  logic signed [ACC_WIDTH-1:0]    w_r, gx_r, gy_r, gz_r, qt_r, p_r;

  dqc_pkg::uop_t                  uop;
  logic signed [OPW-1:0]          add_a, add_b;
  logic signed [OPW:0]            sum;
  logic [OPW-ACC_WIDTH+1:0]       sum_hi;
  logic                           sum_fits;
  logic signed [ACC_WIDTH-1:0]    sat_val;
  logic                           seq_end;

  function automatic logic signed [OPW-1:0] src_val(dqc_pkg::src_t s);
    logic signed [OPW-1:0] v;
    case (s)
      dqc_pkg::SRC_ZERO: v = '0;
      dqc_pkg::SRC_Q:    v = OPW'(q_r);
      dqc_pkg::SRC_X:    v = OPW'(x_r);
      dqc_pkg::SRC_Y:    v = OPW'(y_r);
      dqc_pkg::SRC_Z:    v = OPW'(z_r);
      dqc_pkg::SRC_MX:   v = OPW'(mx_r);
      dqc_pkg::SRC_MY:   v = OPW'(my_r);
      dqc_pkg::SRC_MZ:   v = OPW'(mz_r);
      dqc_pkg::SRC_KG:   v = OPW'(dqc_pkg::K_GRAD);
      dqc_pkg::SRC_KT:   v = OPW'(dqc_pkg::K_TRACE);
      dqc_pkg::SRC_DX:   v = OPW'(dx_r);
      dqc_pkg::SRC_DY:   v = OPW'(dy_r);
      dqc_pkg::SRC_DZ:   v = OPW'(dz_r);
      dqc_pkg::SRC_T:    v = OPW'(t_r);
      dqc_pkg::SRC_W:    v = OPW'(w_r);
      dqc_pkg::SRC_GX:   v = OPW'(gx_r);
      dqc_pkg::SRC_GY:   v = OPW'(gy_r);
      dqc_pkg::SRC_GZ:   v = OPW'(gz_r);
      dqc_pkg::SRC_QT:   v = OPW'(qt_r);
      dqc_pkg::SRC_P:    v = OPW'(p_r);
      default:           v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    uop   = dqc_pkg::uop_rom(step_r);
    mul_a = src_val(uop.ma);
    mul_b = src_val(uop.mb);
    add_a = src_val(uop.aa);
    add_b = src_val(uop.ab);
  end

  // exact sum, clamped to the accumulator range
  assign sum      = (OPW+1)'(add_a) + (OPW+1)'(add_b);
  assign sum_hi   = sum[OPW:ACC_WIDTH-1];
  assign sum_fits = (&sum_hi) | ~(|sum_hi);
  assign sat_val  = sum_fits ? sum[ACC_WIDTH-1:0] : (sum[OPW] ? ACC_MIN : ACC_MAX);
  assign seq_end  = uop.last | (uop.gate & ~dip_en);

  assign mul_ctl.start = (state_r == C_ISSUE) && uop.mul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      step_r  <= dqc_pkg::STEP_PART;
      tgt_r   <= 1'b0;
      ovf_r   <= 1'b0;
      dx_r    <= '0;
      dy_r    <= '0;
      dz_r    <= '0;
      t_r     <= '0;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (start) begin
            x_r  <= pos_x;
            y_r  <= pos_y;
            z_r  <= pos_z;
            q_r  <= charge;
            mx_r <= moment_x;
            my_r <= moment_y;
            mz_r <= moment_z;
            case (dqc_pkg::op_t'(op))
              dqc_pkg::OP_CLEAR: begin
                dx_r  <= '0;
                dy_r  <= '0;
                dz_r  <= '0;
                t_r   <= '0;
                ovf_r <= 1'b0;
              end
              dqc_pkg::OP_PARTICLE: begin
                step_r  <= dqc_pkg::STEP_PART;
                tgt_r   <= 1'b0;
                state_r <= C_ISSUE;
              end
              dqc_pkg::OP_TARGET: begin
                step_r  <= dqc_pkg::STEP_TGT;
                tgt_r   <= 1'b1;
                state_r <= C_ISSUE;
              end
              default: state_r <= C_IDLE;   // unused opcode: dropped
            endcase
          end
        end
        C_ISSUE: begin
          state_r <= uop.mul ? C_WAIT : C_ADD;
        end
        C_WAIT: begin
          if (mul_stat.done) begin
            p_r     <= mul_res;
            ovf_r   <= ovf_r | mul_stat.ovf;
            state_r <= C_ADD;
          end
        end
        C_ADD: begin
          case (uop.dst)
            dqc_pkg::DST_DX: dx_r <= sat_val;
            dqc_pkg::DST_DY: dy_r <= sat_val;
            dqc_pkg::DST_DZ: dz_r <= sat_val;
            dqc_pkg::DST_T:  t_r  <= sat_val;
            dqc_pkg::DST_W:  w_r  <= sat_val;
            dqc_pkg::DST_GX: gx_r <= sat_val;
            dqc_pkg::DST_GY: gy_r <= sat_val;
            dqc_pkg::DST_GZ: gz_r <= sat_val;
            dqc_pkg::DST_QT: qt_r <= sat_val;
            default: ;
          endcase
          ovf_r <= ovf_r | ~sum_fits;
          if (seq_end) begin
            state_r <= tgt_r ? C_OUT : C_IDLE;
          end else begin
            step_r  <= dqc_pkg::STEP_W'(step_r + 1'b1);
            state_r <= C_ISSUE;
          end
        end
        C_OUT: begin
          if (res_ready) begin
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign stat.idle      = (state_r == C_IDLE);
  assign stat.res_valid = (state_r == C_OUT);
  assign pot = w_r;
  assign gx  = gx_r;
  assign gy  = gy_r;
  assign gz  = gz_r;
  assign sat = ovf_r;

endmodule

`default_nettype wire

/* hdl/dipole_quadrupole_correction.sv */
// Multiply steps wait on the one shared multiplier, which works through
// NDIG = ceil(max(ACC_WIDTH, COORD_WIDTH) / 16) digits; add-only steps skip it.
// Particle: the dipole and trace steps, plus the moment steps in dipole mode.
// Target: gradient, scaled trace and potential steps, then the output register; clear: done in idle.
// One item at a time; a result waiting in the output register stalls input only once the next target result is ready.
// Reset (synchronous, rst_n low) zeroes the sums, the saturation flag, the mode bits and the output valid flag.
`default_nettype none

`include "dipole_quadrupole_correction_assert.svh"

module dipole_quadrupole_correction #(
  parameter int COORD_WIDTH = 32,
  parameter int ACC_WIDTH   = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  dqc_in_if.sink                                in_ch,
  dqc_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [dqc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [dqc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int OPW = (ACC_WIDTH > COORD_WIDTH) ? ACC_WIDTH : COORD_WIDTH;

  logic                        dip_en_r, grad_en_r;
  logic                        out_valid_r;
  logic signed [ACC_WIDTH-1:0] pot_out_r, gx_out_r, gy_out_r, gz_out_r;
  logic                        sat_out_r;

  dqc_pkg::core_stat_t         core_stat;
  dqc_pkg::mul_ctl_t           mul_ctl;
  dqc_pkg::mul_stat_t          mul_stat;
  logic signed [OPW-1:0]       mul_a, mul_b;
  logic signed [ACC_WIDTH-1:0] mul_res;
  logic signed [ACC_WIDTH-1:0] pot, gx, gy, gz;
  logic                        sat;
  logic                        in_fire, res_ready, res_fire;

  assign in_ch.ready = core_stat.idle;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign res_ready   = ~out_valid_r | out_ch.ready;
  assign res_fire    = core_stat.res_valid & res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_en_r  <= 1'b0;
      grad_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (dqc_pkg::cfg_idx_t'(cfg_idx))
        dqc_pkg::CFG_DIPOLE_EN:   dip_en_r  <= cfg_wdata[0];
        dqc_pkg::CFG_GRADIENT_EN: grad_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dqc_core #(
    .COORD_WIDTH (COORD_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .op        (in_ch.opcode),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .pos_z     (in_ch.pos_z),
    .charge    (in_ch.charge),
    .moment_x  (in_ch.moment_x),
    .moment_y  (in_ch.moment_y),
    .moment_z  (in_ch.moment_z),
    .dip_en    (dip_en_r),
    .stat      (core_stat),
    .res_ready (res_ready),
    .pot       (pot),
    .gx        (gx),
    .gy        (gy),
    .gz        (gz),
    .sat       (sat),
    .mul_ctl   (mul_ctl),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_stat  (mul_stat),
    .mul_res   (mul_res)
  );

  dqc_mul #(
    .OPW       (OPW),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mul_ctl),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .stat   (mul_stat),
    .result (mul_res)
  );

  // output register: lets the core return to idle while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      pot_out_r <= pot;
      gx_out_r  <= grad_en_r ? gx : '0;
      gy_out_r  <= grad_en_r ? gy : '0;
      gz_out_r  <= grad_en_r ? gz : '0;
      sat_out_r <= sat;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.potential_delta = pot_out_r;
  assign out_ch.gradient_x      = gx_out_r;
  assign out_ch.gradient_y      = gy_out_r;
  assign out_ch.gradient_z      = gz_out_r;
  assign out_ch.saturated       = sat_out_r;

  `DQC_ASSERT_IMP(a_mul_start_idle, mul_ctl.start, mul_stat.idle, "multiply issued while unit busy")
  `DQC_ASSERT_IMP(a_accept_quiet, in_fire, mul_stat.idle && !mul_stat.done, "item taken with multiply in flight")
  `DQC_ASSERT_NXT(a_res_loaded, res_fire, out_valid_r, "result not loaded into output register")

endmodule

`default_nettype wire
